### src/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit: operation
// codes, field widths and the command and status words between controller
// and datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int FUNC_W     = 3;
  localparam int FIELD_W    = 16;
  localparam int NUM_OUT_W  = 33;
  localparam int DEN_OUT_W  = 32;
  localparam int OPER_MAX_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_ADD = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SUB = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_MUL = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DIV = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RED = 3'd4;

  typedef enum logic [2:0] {
    MSEL_NA_DB = 3'd0,
    MSEL_NB_DA = 3'd1,
    MSEL_NA_NB = 3'd2,
    MSEL_DA_DB = 3'd3,
    MSEL_DA_NB = 3'd4
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     den_load;
    logic     res_pass;
    logic     res_clear;
    logic     gcd_init;
    logic     gcd_step;
    logic     g_load;
    logic     div_init_a;
    logic     div_init_b;
    logic     div_step;
    logic     red_num;
    logic     red_den;
    logic     out_load;
  } rau_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              da_zero;
    logic              gcd_done;
    logic              div_last;
    logic              out_free;
  } rau_status_t;

endpackage

### src/rau_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_if
// Valid/ready channels of the rational arithmetic unit: operand channel and
// result channel.
// ----------------------------------------------------------------------------
interface rau_in_if;
  import rau_pkg::*;

  logic                       valid;
  logic                       ready;
  logic        [FUNC_W-1:0]   func;
  logic signed [FIELD_W-1:0]  num_a;
  logic signed [FIELD_W-1:0]  den_a;
  logic signed [FIELD_W-1:0]  num_b;
  logic signed [FIELD_W-1:0]  den_b;

  modport source (output valid, func, num_a, den_a, num_b, den_b, input ready);
  modport sink   (input valid, func, num_a, den_a, num_b, den_b, output ready);
endinterface

interface rau_out_if;
  import rau_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [NUM_OUT_W-1:0] num_out;
  logic signed [DEN_OUT_W-1:0] den_out;
  logic                        valid_res;

  modport source (output valid, num_out, den_out, valid_res, input ready);
  modport sink   (input valid, num_out, den_out, valid_res, output ready);
endinterface

### src/rau_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer of the rational arithmetic unit. Steps the shared multiplier for
// the cross products, the binary gcd loop and the two exact divisions of a
// reduction, then hands the result to the output register.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rau_pkg::rau_status_t status,
  output rau_pkg::rau_cmd_t    cmd
);
  import rau_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_DECODE   = 11'b000_0000_0010,
    ST_PROD1    = 11'b000_0000_0100,
    ST_PROD2    = 11'b000_0000_1000,
    ST_PROD_DEN = 11'b000_0001_0000,
    ST_GCD      = 11'b000_0010_0000,
    ST_DIV_A    = 11'b000_0100_0000,
    ST_RED_MID  = 11'b000_1000_0000,
    ST_DIV_B    = 11'b001_0000_0000,
    ST_RED_END  = 11'b010_0000_0000,
    ST_FINISH   = 11'b100_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   is_addsub;

  assign is_addsub = (status.func == FUNC_ADD) || (status.func == FUNC_SUB);
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (is_addsub) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MSEL_NA_DB;
          state_nxt   = ST_PROD1;
        end else if (status.func == FUNC_MUL) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MSEL_NA_NB;
          state_nxt   = ST_PROD1;
        end else if (status.func == FUNC_DIV) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MSEL_NA_DB;
          state_nxt   = ST_PROD1;
        end else if (status.func == FUNC_RED) begin
          if (status.da_zero) begin
            cmd.res_pass = 1'b1;
            state_nxt    = ST_FINISH;
          end else begin
            cmd.gcd_init = 1'b1;
            state_nxt    = ST_GCD;
          end
        end else begin
          cmd.res_clear = 1'b1;
          state_nxt     = ST_FINISH;
        end
      end
      ST_PROD1: begin
        cmd.acc_op = ACC_LOAD;
        cmd.mul_en = 1'b1;
        priority if (is_addsub) begin
          cmd.mul_sel = MSEL_NB_DA;
          state_nxt   = ST_PROD2;
        end else if (status.func == FUNC_MUL) begin
          cmd.mul_sel = MSEL_DA_DB;
          state_nxt   = ST_PROD_DEN;
        end else begin
          cmd.mul_sel = MSEL_DA_NB;
          state_nxt   = ST_PROD_DEN;
        end
      end
      ST_PROD2: begin
        cmd.acc_op  = (status.func == FUNC_SUB) ? ACC_SUB : ACC_ADD;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_DA_DB;
        state_nxt   = ST_PROD_DEN;
      end
      ST_PROD_DEN: begin
        cmd.den_load = 1'b1;
        state_nxt    = ST_FINISH;
      end
      ST_GCD: begin
        if (status.gcd_done) begin
          cmd.g_load     = 1'b1;
          cmd.div_init_a = 1'b1;
          state_nxt      = ST_DIV_A;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      ST_DIV_A: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_RED_MID;
        end
      end
      ST_RED_MID: begin
        cmd.red_num    = 1'b1;
        cmd.div_init_b = 1'b1;
        state_nxt      = ST_DIV_B;
      end
      ST_DIV_B: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_RED_END;
        end
      end
      ST_RED_END: begin
        cmd.red_den = 1'b1;
        state_nxt   = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // an accepted transaction always leaves idle for decode
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) && in_valid |=> (state_r == ST_DECODE))
    else $error("accepted transaction not decoded");

  // a result is only handed over when the output register can take it
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over a pending transaction");

  // reduction only starts on a reduce with a nonzero denominator
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gcd_init |-> (status.func == FUNC_RED) && !status.da_zero)
    else $error("gcd started on wrong operation");

endmodule

### src/rau_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_dp
// Datapath of the rational arithmetic unit: operand registers, one shared
// signed multiplier with accumulator, binary gcd unit, restoring divider and
// the output register.
// ----------------------------------------------------------------------------
module rau_dp #(
  parameter int OW = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  rau_pkg::rau_cmd_t                       cmd,
  output rau_pkg::rau_status_t                    status,
  input  logic        [rau_pkg::FUNC_W-1:0]       in_func,
  input  logic signed [rau_pkg::FIELD_W-1:0]      in_num_a,
  input  logic signed [rau_pkg::FIELD_W-1:0]      in_den_a,
  input  logic signed [rau_pkg::FIELD_W-1:0]      in_num_b,
  input  logic signed [rau_pkg::FIELD_W-1:0]      in_den_b,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [rau_pkg::NUM_OUT_W-1:0]    out_num_out,
  output logic signed [rau_pkg::DEN_OUT_W-1:0]    out_den_out,
  output logic                                    out_valid_res
);
  import rau_pkg::*;

  localparam int KW = $clog2(OW);
  localparam int CW = $clog2(OW);

  // operand registers
  logic        [FUNC_W-1:0]    func_r, func_nxt;
  logic signed [OW-1:0]        na_r, na_nxt, da_r, da_nxt, nb_r, nb_nxt, db_r, db_nxt;

  // multiplier and accumulator
  logic signed [OW-1:0]        mul_a, mul_b;
  logic signed [2*OW-1:0]      prod_r, prod_nxt;
  logic signed [63:0]          prod_ext;
  logic signed [NUM_OUT_W-1:0] prod_num;
  logic signed [NUM_OUT_W-1:0] acc_r, acc_nxt;
  logic signed [DEN_OUT_W-1:0] den_r, den_nxt;

  // gcd and divider
  logic [OW-1:0]               mag_na, mag_da;
  logic [OW-1:0]               ga_r, ga_nxt, gb_r, gb_nxt, g_r, g_nxt;
  logic [KW-1:0]               k_r, k_nxt;
  logic [OW-1:0]               dq_r, dq_nxt, rem_r, rem_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [OW:0]                 rem_sh, diff;
  logic                        neg;

  // output register
  logic                        ov_r, ov_nxt;
  logic signed [NUM_OUT_W-1:0] onum_r;
  logic signed [DEN_OUT_W-1:0] oden_r;
  logic                        ovres_r;

  logic [OPER_MAX_W-1:0]       ext_na, ext_da, ext_nb, ext_db;

  assign ext_na = OPER_MAX_W'({1'b0, in_num_a});
  assign ext_da = OPER_MAX_W'({1'b0, in_den_a});
  assign ext_nb = OPER_MAX_W'({1'b0, in_num_b});
  assign ext_db = OPER_MAX_W'({1'b0, in_den_b});

  assign mag_na   = na_r[OW-1] ? OW'(-na_r) : OW'(na_r);
  assign mag_da   = da_r[OW-1] ? OW'(-da_r) : OW'(da_r);
  assign neg      = na_r[OW-1] ^ da_r[OW-1];
  assign prod_ext = 64'(prod_r);
  assign prod_num = prod_ext[NUM_OUT_W-1:0];
  assign rem_sh   = {rem_r, dq_r[OW-1]};
  assign diff     = rem_sh - {1'b0, g_r};

  always_comb begin
    unique case (cmd.mul_sel)
      MSEL_NA_DB: begin mul_a = na_r; mul_b = db_r; end
      MSEL_NB_DA: begin mul_a = nb_r; mul_b = da_r; end
      MSEL_NA_NB: begin mul_a = na_r; mul_b = nb_r; end
      MSEL_DA_DB: begin mul_a = da_r; mul_b = db_r; end
      MSEL_DA_NB: begin mul_a = da_r; mul_b = nb_r; end
      default:    begin mul_a = na_r; mul_b = db_r; end
    endcase
  end

  always_comb begin
    func_nxt = func_r;
    na_nxt   = na_r;
    da_nxt   = da_r;
    nb_nxt   = nb_r;
    db_nxt   = db_r;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    den_nxt  = den_r;
    ga_nxt   = ga_r;
    gb_nxt   = gb_r;
    k_nxt    = k_r;
    g_nxt    = g_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;

    if (cmd.load) begin
      func_nxt = in_func;
      na_nxt   = ext_na[OW-1:0];
      da_nxt   = ext_da[OW-1:0];
      nb_nxt   = ext_nb[OW-1:0];
      db_nxt   = ext_db[OW-1:0];
    end

    if (cmd.mul_en) begin
      prod_nxt = mul_a * mul_b;
    end

    unique case (cmd.acc_op)
      ACC_HOLD: ;
      ACC_LOAD: acc_nxt = prod_num;
      ACC_ADD:  acc_nxt = acc_r + prod_num;
      ACC_SUB:  acc_nxt = acc_r - prod_num;
      default:  ;
    endcase

    if (cmd.den_load) begin
      den_nxt = prod_ext[DEN_OUT_W-1:0];
    end
    if (cmd.res_pass) begin
      acc_nxt = NUM_OUT_W'(na_r);
      den_nxt = '0;
    end
    if (cmd.res_clear) begin
      acc_nxt = '0;
      den_nxt = '0;
    end

    // binary gcd on the magnitudes
    if (cmd.gcd_init) begin
      ga_nxt = mag_na;
      gb_nxt = mag_da;
      k_nxt  = '0;
    end
    if (cmd.gcd_step) begin
      priority if (!ga_r[0] && !gb_r[0]) begin
        ga_nxt = ga_r >> 1;
        gb_nxt = gb_r >> 1;
        k_nxt  = k_r + KW'(1);
      end else if (!ga_r[0]) begin
        ga_nxt = ga_r >> 1;
      end else if (!gb_r[0]) begin
        gb_nxt = gb_r >> 1;
      end else if (ga_r >= gb_r) begin
        ga_nxt = (ga_r - gb_r) >> 1;
      end else begin
        gb_nxt = (gb_r - ga_r) >> 1;
      end
    end
    if (cmd.g_load) begin
      g_nxt = (ga_r | gb_r) << k_r;
    end

    // restoring divider, one quotient bit per cycle
    if (cmd.div_init_a) begin
      dq_nxt  = mag_na;
      rem_nxt = '0;
      cnt_nxt = CW'(OW - 1);
    end
    if (cmd.div_init_b) begin
      dq_nxt  = mag_da;
      rem_nxt = '0;
      cnt_nxt = CW'(OW - 1);
    end
    if (cmd.div_step) begin
      if (!diff[OW]) begin
        rem_nxt = diff[OW-1:0];
        dq_nxt  = {dq_r[OW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[OW-1:0];
        dq_nxt  = {dq_r[OW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
    end

    if (cmd.red_num) begin
      acc_nxt = neg ? -NUM_OUT_W'(dq_r) : NUM_OUT_W'(dq_r);
    end
    if (cmd.red_den) begin
      den_nxt = DEN_OUT_W'(dq_r);
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (cmd.out_load) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    na_r   <= na_nxt;
    da_r   <= da_nxt;
    nb_r   <= nb_nxt;
    db_r   <= db_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    den_r  <= den_nxt;
    ga_r   <= ga_nxt;
    gb_r   <= gb_nxt;
    k_r    <= k_nxt;
    g_r    <= g_nxt;
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    if (cmd.out_load) begin
      onum_r  <= acc_r;
      oden_r  <= den_r;
      ovres_r <= (den_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  assign status.func     = func_r;
  assign status.da_zero  = (da_r == '0);
  assign status.gcd_done = (ga_r == '0) || (gb_r == '0);
  assign status.div_last = (cnt_r == '0);
  assign status.out_free = !ov_r || out_ready;

  assign out_valid     = ov_r;
  assign out_num_out   = onum_r;
  assign out_den_out   = oden_r;
  assign out_valid_res = ovres_r;

  // gcd steps only run while both values are nonzero
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gcd_step |-> (ga_r != '0) && (gb_r != '0))
    else $error("gcd step on finished values");

  // common power of two never exceeds the operand width
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gcd_step && !ga_r[0] && !gb_r[0] |-> (k_r != KW'(OW - 1)))
    else $error("gcd shift count overflow");

  // the gcd divides the numerator exactly
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.red_num |-> (rem_r == '0))
    else $error("numerator division left a remainder");

  // the gcd divides the denominator exactly
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.red_den |-> (rem_r == '0))
    else $error("denominator division left a remainder");

endmodule

### src/rational_arith_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_unit
// Add, subtract, multiply and divide of signed fractions by cross
// multiplication, and gcd reduction of the first operand.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in_ch    sink       valid/ready        func, num_a, den_a, num_b, den_b
//  out_ch   source     valid/ready        num_out, den_out, valid_res
//
//  add and subtract take three multiplier products per transaction, multiply
//  and divide two, all paced by the single shared multiplier.
//  reduce runs the binary gcd loop and then two exact divisions in the
//  restoring divider; a zero denominator on reduce skips both and passes
//  the numerator through.
//  one transaction is worked at a time; the next one is accepted while the
//  previous result waits in the output register.
//  synchronous active-low reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module rational_arith_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input logic       clk,
  input logic       rst_n,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);
  import rau_pkg::*;

  rau_cmd_t    cmd;
  rau_status_t status;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rau_dp #(
    .OW (OPERAND_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_func       (in_ch.func),
    .in_num_a      (in_ch.num_a),
    .in_den_a      (in_ch.den_a),
    .in_num_b      (in_ch.num_b),
    .in_den_b      (in_ch.den_b),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_num_out   (out_ch.num_out),
    .out_den_out   (out_ch.den_out),
    .out_valid_res (out_ch.valid_res)
  );

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rational arithmetic unit. Operand transactions
// are sent over the valid/ready input channel in random bursts. The expected
// fraction of each accepted transaction is computed here and queued. Every
// result transaction is compared field by field with the oldest queued
// fraction while the result side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_top;
  import rau_pkg::*;

  localparam int OPW          = 16;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int END_LATENCY  = 120;
  localparam int RANDOM_ITEMS = 600;

  // selector codes with no operation behind them
  localparam logic [FUNC_W-1:0] FUNC_SPARE5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE7 = 3'd7;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [FIELD_W-1:0] num_a;
    logic [FIELD_W-1:0] den_a;
    logic [FIELD_W-1:0] num_b;
    logic [FIELD_W-1:0] den_b;
  } operands_t;

  typedef struct {
    logic signed [NUM_OUT_W-1:0] num;
    logic signed [DEN_OUT_W-1:0] den;
    logic                        vres;
  } fraction_t;

  logic clk = 1'b0;
  logic rst_n;

  rau_in_if  in_ch ();
  rau_out_if out_ch ();

  rational_arith_unit #(.OPERAND_WIDTH(OPW)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  fraction_t pending_fractions[$];
  fraction_t oldest_fraction;
  int        error_count     = 0;
  int        results_checked = 0;
  int        op_count[8]     = '{default: 0};
  int        cycle_count     = 0;
  int        hold_off_cycles = 0;
  int        rx_seg_left     = 0;
  int        rx_mode         = 0;

  // ---------------------------------------------------------------- predictor
  function automatic longint widen_operand(input logic [FIELD_W-1:0] v);
    logic [63:0] u;
    u = 64'(v) & ((64'd1 << OPW) - 64'd1);
    if (u[OPW-1]) u = u - (64'd1 << OPW);
    return longint'(u);
  endfunction

  function automatic longint magnitude(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint common_divisor(input longint a, input longint b);
    longint t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic fraction_t compute_fraction(input operands_t op);
    fraction_t r;
    longint    na, da, nb, db, n, d, g, rn, rd;
    logic      known;
    na    = widen_operand(op.num_a);
    da    = widen_operand(op.den_a);
    nb    = widen_operand(op.num_b);
    db    = widen_operand(op.den_b);
    n     = 0;
    d     = 0;
    known = 1'b1;
    case (op.func)
      FUNC_ADD: begin
        n = na * db + nb * da;
        d = da * db;
      end
      FUNC_SUB: begin
        n = na * db - nb * da;
        d = da * db;
      end
      FUNC_MUL: begin
        n = na * nb;
        d = da * db;
      end
      FUNC_DIV: begin
        n = na * db;
        d = da * nb;
      end
      FUNC_RED: begin
        if (da == 0) begin
          n = na;
          d = 0;
        end else begin
          g  = (na == 0) ? magnitude(da) : common_divisor(magnitude(na), magnitude(da));
          rn = na / g;
          rd = da / g;
          if (rd < 0) begin
            rn = -rn;
            rd = -rd;
          end
          n = rn;
          d = rd;
        end
      end
      default: known = 1'b0;
    endcase
    r.num  = n[NUM_OUT_W-1:0];
    r.den  = d[DEN_OUT_W-1:0];
    r.vres = known && (r.den != 0);
    return r;
  endfunction

  // ---------------------------------------------------------------- sender
  task automatic send_operands(input logic [FUNC_W-1:0] f, input logic [FIELD_W-1:0] na,
                               input logic [FIELD_W-1:0] da, input logic [FIELD_W-1:0] nb,
                               input logic [FIELD_W-1:0] db);
    operands_t op;
    op.func  = f;
    op.num_a = na;
    op.den_a = da;
    op.num_b = nb;
    op.den_b = db;
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.num_a <= na;
    in_ch.den_a <= da;
    in_ch.num_b <= nb;
    in_ch.den_b <= db;
    do @(posedge clk); while (!in_ch.ready);
    pending_fractions.push_back(compute_fraction(op));
    op_count[f]++;
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles == 0) return;
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_fractions.size() != 0) @(posedge clk);
  endtask

  function automatic logic [FIELD_W-1:0] pick_operand();
    int sel;
    int pick;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      pick = $urandom_range(0, 4);
      case (pick)
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'h0000;
        3: return 16'h0001;
        default: return 16'hffff;
      endcase
    end else if (sel <= 3) begin
      return FIELD_W'(int'($urandom_range(0, 40)) - 20);
    end
    return FIELD_W'($urandom_range(0, 65535));
  endfunction

  // ---------------------------------------------------------------- receiver
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        if (rx_seg_left == 0) begin
          rx_mode     = $urandom_range(0, 2);
          rx_seg_left = $urandom_range(20, 200);
        end
        rx_seg_left--;
        case (rx_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ((rx_seg_left % 11) < 4);
        endcase
      end
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_fractions.size() == 0) begin
        $error("unexpected result transaction: num_out %0d den_out %0d valid_res %0b",
               out_ch.num_out, out_ch.den_out, out_ch.valid_res);
        error_count++;
      end else begin
        oldest_fraction = pending_fractions.pop_front();
        results_checked++;
        if (out_ch.num_out !== oldest_fraction.num) begin
          $error("num_out: expected %0d, got %0d", oldest_fraction.num, out_ch.num_out);
          error_count++;
        end
        if (out_ch.den_out !== oldest_fraction.den) begin
          $error("den_out: expected %0d, got %0d", oldest_fraction.den, out_ch.den_out);
          error_count++;
        end
        if (out_ch.valid_res !== oldest_fraction.vres) begin
          $error("valid_res: expected %0b, got %0b", oldest_fraction.vres, out_ch.valid_res);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_fractions.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    send_operands(FUNC_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_operands(FUNC_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_operands(FUNC_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_operands(FUNC_SUB, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
    send_operands(FUNC_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_operands(FUNC_MUL, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_operands(FUNC_DIV, 16'h8000, 16'h7fff, 16'h0000, 16'h8000);
    send_operands(FUNC_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
    send_operands(FUNC_ADD, 16'd5, 16'd0, 16'd3, 16'd7);
    send_operands(FUNC_MUL, 16'd5, 16'd9, 16'd3, 16'd0);
    // zero numerator, with negative and positive denominators
    send_operands(FUNC_RED, 16'd0, -16'sd7, 16'd0, 16'd0);
    send_operands(FUNC_RED, 16'd0, 16'h7fff, 16'd0, 16'd0);
    // zero denominator passes through marked invalid
    send_operands(FUNC_RED, 16'd9, 16'd0, 16'd0, 16'd0);
    send_operands(FUNC_RED, 16'h8000, 16'd0, 16'd0, 16'd0);
    // negative denominators, and one positive denominator with the most negative numerator
    send_operands(FUNC_RED, 16'd12, -16'sd18, 16'd0, 16'd0);
    send_operands(FUNC_RED, 16'h8000, 16'h8000, 16'd0, 16'd0);
    send_operands(FUNC_RED, 16'h8000, 16'h7fff, 16'd0, 16'd0);
    send_operands(FUNC_RED, 16'h7fff, 16'hffff, 16'd0, 16'd0);
    send_operands(FUNC_RED, 16'h8000, -16'sd2, 16'd0, 16'd0);
    // b operand ignored on reduce
    send_operands(FUNC_RED, 16'd30, 16'd45, 16'h7fff, 16'h8000);
    send_operands(FUNC_SPARE5, 16'd3, 16'd4, 16'd5, 16'd6);
    send_operands(FUNC_SPARE6, 16'h8000, 16'h7fff, 16'hffff, 16'h0001);
    send_operands(FUNC_SPARE7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_off_cycles = 400;
    for (int i = 0; i < 16; i++) begin
      send_operands(3'($urandom_range(0, 4)), pick_operand(), pick_operand(),
                    pick_operand(), pick_operand());
    end
    wait_drained();
  endtask

  task automatic test_random();
    int                 burst_left;
    int                 r;
    int                 k;
    int                 lim;
    logic [FUNC_W-1:0]  f;
    logic [FIELD_W-1:0] na, da;
    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (burst_left == 0) begin
        idle_sender($urandom_range(1, 12));
        burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      r = $urandom_range(0, 19);
      if (r < 4)       f = FUNC_ADD;
      else if (r < 7)  f = FUNC_SUB;
      else if (r < 10) f = FUNC_MUL;
      else if (r < 13) f = FUNC_DIV;
      else if (r < 18) f = FUNC_RED;
      else             f = 3'($urandom_range(5, 7));
      na = pick_operand();
      da = pick_operand();
      // reduce gets operands with a shared factor half of the time
      if (f == FUNC_RED && $urandom_range(0, 1)) begin
        k   = $urandom_range(1, 300);
        lim = 32767 / k;
        na  = FIELD_W'((int'($urandom_range(0, 2 * lim)) - lim) * k);
        da  = FIELD_W'((int'($urandom_range(0, 2 * lim)) - lim) * k);
      end
      send_operands(f, na, da, pick_operand(), pick_operand());
      if (i % 150 == 149) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.func   <= FUNC_ADD;
    in_ch.num_a  <= '0;
    in_ch.den_a  <= '0;
    in_ch.num_b  <= '0;
    in_ch.den_b  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    repeat (END_LATENCY) @(posedge clk);
    $display("covered %0d add, %0d sub, %0d mul, %0d div, %0d reduce, %0d spare-code transactions",
             op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
             op_count[5] + op_count[6] + op_count[7]);
    $display("%0d results compared under bursty input and stalled output", results_checked);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
